// ===== rtl/point_in_polygon_test_top_macros.svh =====
`ifndef POINT_IN_POLYGON_TEST_TOP_MACROS_SVH
`define POINT_IN_POLYGON_TEST_TOP_MACROS_SVH

// same-cycle implication
`define PIP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("point_in_polygon_test: same-cycle check failed");

// next-cycle implication
`define PIP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("point_in_polygon_test: next-cycle check failed");

`endif

// ===== rtl/pip_pkg.sv =====
package pip_pkg;

    localparam int PIP_MAX_VERTICES = 1024;
    localparam int PIP_MIN_POLY     = 3;
    localparam int PIP_PAW          = 3;
    localparam int PIP_PDW          = 32;

    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;

    localparam logic [1:0] ST_STORED  = 2'd0;
    localparam logic [1:0] ST_DROPPED = 2'd1;
    localparam logic [1:0] ST_CLEARED = 2'd2;
    localparam logic [1:0] ST_QUERY   = 2'd3;

    localparam logic CFG_IDX_CLOSED = 1'b0;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
    } t_vertex;

    typedef struct packed {
        logic clear;
        logic vld;
        logic last;
    } t_edge_ctl;

    typedef struct packed {
        logic done;
        logic parity;
        logic boundary;
    } t_edge_res;

endpackage

// ===== rtl/pip_ram.sv =====
module pip_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/pip_edge.sv =====
module pip_edge import pip_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_edge_ctl i_ctl,
    input  t_vertex   i_prev,
    input  t_vertex   i_next,
    input  t_vertex   i_pt,
    output t_edge_res o_res
);

    logic signed [31:0] ix, iy, nx, ny, px, py;
    logic signed [32:0] da, db, dc, de;

    assign ix = i_prev.x;
    assign iy = i_prev.y;
    assign nx = i_next.x;
    assign ny = i_next.y;
    assign px = i_pt.x;
    assign py = i_pt.y;

    assign da = $signed({ix[31], ix}) - $signed({px[31], px});
    assign db = $signed({ny[31], ny}) - $signed({py[31], py});
    assign dc = $signed({nx[31], nx}) - $signed({px[31], px});
    assign de = $signed({iy[31], iy}) - $signed({py[31], py});

    // stage valid/last
    logic [3:0] r_vld;
    logic [3:0] r_last;

    // stage 1: compares and differences
    logic               r1_bnd, r1_tog, r1_need, r1_up;
    logic signed [32:0] r1_a, r1_b, r1_c, r1_e;
    // stage 2: magnitudes
    logic [32:0] r2_ma, r2_mb, r2_mc, r2_me;
    logic        r2_sp, r2_sq;
    logic        r2_bnd, r2_tog, r2_need, r2_up;
    // stage 3: partial products
    logic [63:0] r3_plo, r3_qlo;
    logic [32:0] r3_pmid, r3_qmid;
    logic        r3_ptop, r3_qtop;
    logic        r3_sp, r3_sq;
    logic        r3_bnd, r3_tog, r3_need, r3_up;
    // stage 4: full magnitudes
    logic [65:0] r4_p, r4_q;
    logic        r4_sp, r4_sq;
    logic        r4_bnd, r4_tog, r4_need, r4_up;

    logic        r_par, r_bnd, r_done;

    logic s1_bnd, s1_cross, s1_tog, s1_need;

    always_comb begin
        s1_bnd   = (ny == py) && ((nx == px) || ((iy == py) && ((nx > px) == (ix < px))));
        s1_cross = (iy < py) != (ny < py);
        s1_tog   = s1_cross && (ix >= px) && (nx > px);
        s1_need  = s1_cross && ((ix >= px) ? !(nx > px) : (nx > px));
    end

    logic [65:0] p_sum, q_sum;
    assign p_sum = {2'b0, r3_plo} + {1'b0, r3_pmid, 32'd0} + {1'b0, r3_ptop, 64'd0};
    assign q_sum = {2'b0, r3_qlo} + {1'b0, r3_qmid, 32'd0} + {1'b0, r3_qtop, 64'd0};

    logic np, nq, s_zero, s_pos, e_bnd, e_tog;

    always_comb begin
        np     = r4_sp && (r4_p != '0);
        nq     = r4_sq && (r4_q != '0);
        s_zero = 1'b0;
        s_pos  = 1'b0;
        if (np != nq) begin
            s_pos = !np;
        end else if (r4_p == r4_q) begin
            s_zero = 1'b1;
        end else if (!np) begin
            s_pos = r4_p > r4_q;
        end else begin
            s_pos = !(r4_p > r4_q);
        end
        e_bnd = r4_bnd || (r4_need && s_zero);
        e_tog = r4_tog || (r4_need && !s_zero && (s_pos == r4_up));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_par  <= 1'b0;
            r_bnd  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_vld  <= {r_vld[2:0], i_ctl.vld};
            r_done <= r_vld[3] && r_last[3];
            if (i_ctl.clear) begin
                r_par <= 1'b0;
                r_bnd <= 1'b0;
            end else if (r_vld[3]) begin
                r_par <= r_par ^ e_tog;
                r_bnd <= r_bnd | e_bnd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_last  <= {r_last[2:0], i_ctl.last};

        r1_bnd  <= s1_bnd;
        r1_tog  <= s1_tog;
        r1_need <= s1_need;
        r1_up   <= ny > iy;
        r1_a    <= da;
        r1_b    <= db;
        r1_c    <= dc;
        r1_e    <= de;

        r2_ma   <= r1_a[32] ? (~r1_a + 33'd1) : r1_a;
        r2_mb   <= r1_b[32] ? (~r1_b + 33'd1) : r1_b;
        r2_mc   <= r1_c[32] ? (~r1_c + 33'd1) : r1_c;
        r2_me   <= r1_e[32] ? (~r1_e + 33'd1) : r1_e;
        r2_sp   <= r1_a[32] ^ r1_b[32];
        r2_sq   <= r1_c[32] ^ r1_e[32];
        r2_bnd  <= r1_bnd;
        r2_tog  <= r1_tog;
        r2_need <= r1_need;
        r2_up   <= r1_up;

        r3_plo  <= r2_ma[31:0] * r2_mb[31:0];
        r3_qlo  <= r2_mc[31:0] * r2_me[31:0];
        r3_pmid <= {1'b0, (r2_ma[32] ? r2_mb[31:0] : 32'd0)}
                 + {1'b0, (r2_mb[32] ? r2_ma[31:0] : 32'd0)};
        r3_qmid <= {1'b0, (r2_mc[32] ? r2_me[31:0] : 32'd0)}
                 + {1'b0, (r2_me[32] ? r2_mc[31:0] : 32'd0)};
        r3_ptop <= r2_ma[32] & r2_mb[32];
        r3_qtop <= r2_mc[32] & r2_me[32];
        r3_sp   <= r2_sp;
        r3_sq   <= r2_sq;
        r3_bnd  <= r2_bnd;
        r3_tog  <= r2_tog;
        r3_need <= r2_need;
        r3_up   <= r2_up;

        r4_p    <= p_sum;
        r4_q    <= q_sum;
        r4_sp   <= r3_sp;
        r4_sq   <= r3_sq;
        r4_bnd  <= r3_bnd;
        r4_tog  <= r3_tog;
        r4_need <= r3_need;
        r4_up   <= r3_up;
    end

    assign o_res.done     = r_done;
    assign o_res.parity   = r_par;
    assign o_res.boundary = r_bnd;

endmodule

// ===== rtl/point_in_polygon_test_top.sv =====
// Channel  Direction  Handshake                     Payload
// in       input      i_in_valid / o_in_stall       i_mode, i_coord_x, i_coord_y
// out      output     o_out_valid / i_out_stall     o_status, o_inside_res, o_on_boundary
// cfg      input      psel / penable / pwrite       paddr, pwdata, prdata, pready
//
// Clear, append and a query on an open or small polygon answer in the cycle after they are accepted.
// A full query reads the vertex store one vertex per cycle
// over all vertices plus the closing one, then the edge pipeline drains.
// Synchronous active-low reset empties the store (count to zero) and opens the chain.
// The input stalls while a query walks or drains and while a result waits under output stall.
module point_in_polygon_test_top import pip_pkg::*; #(
    parameter int MAX_VERTICES = PIP_MAX_VERTICES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_mode,
    input  logic signed [31:0]  i_coord_x,
    input  logic signed [31:0]  i_coord_y,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [1:0]          o_status,
    output logic                o_inside_res,
    output logic                o_on_boundary,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PIP_PAW-1:0]  paddr,
    input  logic [PIP_PDW-1:0]  pwdata,
    output logic [PIP_PDW-1:0]  prdata,
    output logic                pready
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);

    typedef enum logic [1:0] {S_IDLE, S_WALK, S_DRAIN} t_state;

    t_state      r_state;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_idx;
    logic        r_closed;
    logic        r_out_valid;
    logic        n_out_valid;
    logic [1:0]  r_status;
    logic        r_inside;
    logic        r_onb;
    logic        r_rd_vld;
    logic        r_rd_first;
    logic        r_rd_last;
    t_vertex     r_pt;
    t_vertex     r_prev;

    logic        in_acc;
    logic        is_query;
    logic        room;
    logic        eligible;
    logic        ram_we;
    logic        ram_re;
    logic [AW-1:0] ram_raddr;
    t_vertex     wr_vtx;
    t_vertex     rd_vtx;
    t_edge_ctl   ectl;
    t_edge_res   eres;

    assign o_in_stall = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign is_query   = (i_mode != MODE_CLEAR) && (i_mode != MODE_APPEND);
    assign room       = r_cnt < CW'(MAX_VERTICES);
    assign eligible   = r_closed && (r_cnt >= CW'(PIP_MIN_POLY));

    assign wr_vtx.x   = i_coord_x;
    assign wr_vtx.y   = i_coord_y;
    assign ram_we     = in_acc && (i_mode == MODE_APPEND) && room;
    assign ram_re     = r_state == S_WALK;
    assign ram_raddr  = (r_idx == r_cnt) ? '0 : r_idx[AW-1:0];

    pip_ram #(
        .WIDTH ($bits(t_vertex)),
        .DEPTH (MAX_VERTICES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (wr_vtx),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (rd_vtx)
    );

    assign ectl.clear = in_acc && is_query;
    assign ectl.vld   = r_rd_vld && !r_rd_first;
    assign ectl.last  = r_rd_last;

    pip_edge u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ectl),
        .i_prev  (r_prev),
        .i_next  (rd_vtx),
        .i_pt    (r_pt),
        .o_res   (eres)
    );

    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if ((r_state == S_IDLE) && in_acc && !(is_query && eligible)) begin
            n_out_valid = 1'b1;
        end
        if ((r_state == S_DRAIN) && eres.done) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_idx       <= '0;
            r_closed    <= 1'b0;
            r_out_valid <= 1'b0;
            r_status    <= ST_STORED;
            r_inside    <= 1'b0;
            r_onb       <= 1'b0;
            r_rd_vld    <= 1'b0;
        end else begin
            if (psel && penable && pwrite && pready && (paddr[2] == CFG_IDX_CLOSED)) begin
                r_closed <= pwdata[0];
            end
            r_rd_vld    <= r_state == S_WALK;
            r_out_valid <= n_out_valid;
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_inside <= 1'b0;
                        r_onb    <= 1'b0;
                        case (i_mode)
                            MODE_CLEAR: begin
                                r_cnt    <= '0;
                                r_status <= ST_CLEARED;
                            end
                            MODE_APPEND: begin
                                if (room) begin
                                    r_cnt    <= r_cnt + CW'(1);
                                    r_status <= ST_STORED;
                                end else begin
                                    r_status <= ST_DROPPED;
                                end
                            end
                            default: begin
                                if (eligible) begin
                                    r_idx   <= '0;
                                    r_state <= S_WALK;
                                end else begin
                                    r_status <= ST_QUERY;
                                end
                            end
                        endcase
                    end
                end
                S_WALK: begin
                    r_idx <= r_idx + CW'(1);
                    if (r_idx == r_cnt) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (eres.done) begin
                        r_status <= ST_QUERY;
                        r_inside <= eres.parity | eres.boundary;
                        r_onb    <= eres.boundary;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_pt.x <= i_coord_x;
            r_pt.y <= i_coord_y;
        end
        r_rd_first <= r_idx == '0;
        r_rd_last  <= r_idx == r_cnt;
        if (r_rd_vld) begin
            r_prev <= rd_vtx;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_inside_res  = r_inside;
    assign o_on_boundary = r_onb;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == CFG_IDX_CLOSED) ? {{(PIP_PDW-1){1'b0}}, r_closed} : '0;

endmodule

// ===== rtl/pip_checker.sv =====
`include "point_in_polygon_test_top_macros.svh"

module pip_checker import pip_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [1:0] o_status,
    input logic       o_inside_res,
    input logic       o_on_boundary
);

    logic non_query;
    logic flags_clear;

    assign non_query   = o_out_valid && (o_status != ST_QUERY);
    assign flags_clear = !o_inside_res && !o_on_boundary;

    `PIP_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, i_in_valid && o_in_stall, i_in_valid)
    `PIP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)
    `PIP_ASSERT_NOW(a_no_accept_blocked, i_clk, i_rst_n, o_out_valid && i_out_stall, o_in_stall)
    `PIP_ASSERT_NOW(a_flags_query_only, i_clk, i_rst_n, non_query, flags_clear)
    `PIP_ASSERT_NOW(a_boundary_inside, i_clk, i_rst_n, o_out_valid && o_on_boundary, o_inside_res)

endmodule

bind point_in_polygon_test_top pip_checker u_pip_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_status      (o_status),
    .o_inside_res  (o_inside_res),
    .o_on_boundary (o_on_boundary)
);
